/* rtl/rtad_pkg.sv */
// shared types, constants and glyph function for the radix to ascii digit converter
package rtad_pkg;

  localparam int RADIX_W = 5;
  localparam int DIGIT_W = 4;
  localparam int CHAR_W = 7;
  localparam int STEP_BITS = 8;

  localparam logic [RADIX_W-1:0] RADIX_RESET = 5'd10;
  localparam logic [RADIX_W-1:0] RADIX_MIN = 5'd2;
  localparam logic [RADIX_W-1:0] RADIX_MAX = 5'd16;

  localparam logic [DIGIT_W-1:0] DEC_DIGITS = 4'd10;
  localparam logic [CHAR_W-1:0] ASCII_ZERO = 7'd48;
  localparam logic [CHAR_W-1:0] ASCII_NINE = 7'd57;
  localparam logic [CHAR_W-1:0] ASCII_A = 7'd65;
  localparam logic [CHAR_W-1:0] ASCII_F = 7'd70;

  typedef struct packed {
    logic load;
    logic div;
    logic emit;
  } rtad_cmd_t;

  typedef struct packed {
    logic last_step;
    logic more;
    logic emit_last;
  } rtad_status_t;

  function automatic logic [CHAR_W-1:0] digit_glyph(input logic [DIGIT_W-1:0] d);
    logic [CHAR_W-1:0] c;
    if (d < DEC_DIGITS) begin
      c = ASCII_ZERO + CHAR_W'(d);
    end else begin
      c = ASCII_A + CHAR_W'(d - DEC_DIGITS);
    end
    return c;
  endfunction

endpackage

/* rtl/rtad_ram.sv */
// generic single write port ram with registered read
module rtad_ram #(
  parameter int WIDTH = 4,
  parameter int DEPTH = 31
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

/* rtl/rtad_ctrl.sv */
// controller state machine: load, divide per digit, emit digits, flush
module rtad_ctrl import rtad_pkg::*; (
  input  logic         clk,
  input  logic         rst,
  input  logic         start,
  input  rtad_status_t status,
  output rtad_cmd_t    cmd,
  output logic         busy
);

  typedef enum logic [3:0] {
    S_IDLE  = 4'b0001,
    S_DIV   = 4'b0010,
    S_EMIT  = 4'b0100,
    S_FLUSH = 4'b1000
  } state_t;

  state_t state, state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    cmd = '0;
    case (state)
      S_IDLE: begin
        if (start) begin
          cmd.load = 1'b1;
          state_next = S_DIV;
        end
      end
      S_DIV: begin
        cmd.div = 1'b1;
        if (status.last_step && !status.more) begin
          state_next = S_EMIT;
        end
      end
      S_EMIT: begin
        cmd.emit = 1'b1;
        if (status.emit_last) begin
          state_next = S_FLUSH;
        end
      end
      S_FLUSH: begin
        state_next = S_IDLE;
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  assign busy = (state != S_IDLE);

endmodule

/* rtl/rtad_dpath.sv */
// datapath: radix register, short divider, digit store and output stage
module rtad_dpath import rtad_pkg::*; #(
  parameter int VALUE_BITS = 31,
  parameter int MAX_DIGITS = 31
) (
  input  logic                  clk,
  input  logic                  rst,
  input  rtad_cmd_t             cmd,
  output rtad_status_t          status,
  input  logic [VALUE_BITS-1:0] value,
  input  logic                  radix_we,
  input  logic [RADIX_W-1:0]    radix,
  output logic                  digit_valid,
  output logic [CHAR_W-1:0]     digit_char,
  output logic                  last_digit
);

  localparam int STEPS = (VALUE_BITS + STEP_BITS - 1) / STEP_BITS;
  localparam int W = STEPS * STEP_BITS;
  localparam int SW = (STEPS > 1) ? $clog2(STEPS) : 1;
  localparam int AW = $clog2(MAX_DIGITS);
  localparam int CW = $clog2(MAX_DIGITS + 1);

  logic [RADIX_W-1:0] base;
  logic [RADIX_W-1:0] base_eff;
  logic [W-1:0]       w;
  logic [W-1:0]       w_next;
  logic [DIGIT_W-1:0] rem;
  logic [DIGIT_W-1:0] rem_next;
  logic [STEP_BITS-1:0] qbits;
  logic [DIGIT_W:0]   trial;
  logic [SW-1:0]      step;
  logic [CW-1:0]      count;
  logic [CW-1:0]      count_inc;
  logic [CW-1:0]      count_dec;
  logic               out_valid;
  logic               out_last;
  logic [DIGIT_W-1:0] rd_digit;
  logic               digit_we;

  always_ff @(posedge clk) begin
    if (rst) begin
      base <= RADIX_RESET;
    end else if (radix_we) begin
      base <= radix;
    end
  end

  always_comb begin
    if (base < RADIX_MIN) begin
      base_eff = RADIX_MIN;
    end else if (base > RADIX_MAX) begin
      base_eff = RADIX_MAX;
    end else begin
      base_eff = base;
    end
  end

  // restoring short division, STEP_BITS quotient bits per cycle
  always_comb begin
    rem_next = rem;
    qbits = '0;
    trial = '0;
    for (int i = 0; i < STEP_BITS; i++) begin
      trial = {rem_next, w[W-1-i]};
      if (trial >= base_eff) begin
        rem_next = DIGIT_W'(trial - base_eff);
        qbits[STEP_BITS-1-i] = 1'b1;
      end else begin
        rem_next = trial[DIGIT_W-1:0];
      end
    end
    w_next = (w << STEP_BITS) | W'(qbits);
  end

  assign count_inc = count + CW'(1);
  assign count_dec = count - CW'(1);

  assign status.last_step = (step == SW'(STEPS - 1));
  assign status.more = (w_next != '0) && (count_inc != CW'(MAX_DIGITS));
  assign status.emit_last = (count == CW'(1));

  assign digit_we = cmd.div && status.last_step;

  always_ff @(posedge clk) begin
    if (rst) begin
      step <= '0;
      count <= '0;
      out_valid <= 1'b0;
    end else begin
      out_valid <= cmd.emit;
      if (cmd.load) begin
        step <= '0;
        count <= '0;
      end else if (cmd.div) begin
        if (status.last_step) begin
          step <= '0;
          count <= count_inc;
        end else begin
          step <= step + SW'(1);
        end
      end else if (cmd.emit) begin
        count <= count_dec;
      end
    end
  end

  always_ff @(posedge clk) begin
    out_last <= status.emit_last;
    if (cmd.load) begin
      w <= W'(value);
      rem <= '0;
    end else if (cmd.div) begin
      w <= w_next;
      rem <= status.last_step ? '0 : rem_next;
    end
  end

  rtad_ram #(
    .WIDTH(DIGIT_W),
    .DEPTH(MAX_DIGITS)
  ) u_store (
    .clk  (clk),
    .we   (digit_we),
    .waddr(count[AW-1:0]),
    .wdata(rem_next),
    .re   (cmd.emit),
    .raddr(count_dec[AW-1:0]),
    .rdata(rd_digit)
  );

  assign digit_valid = out_valid;
  assign digit_char = digit_glyph(rd_digit);
  assign last_digit = out_valid && out_last;

  a_last_ends_item: assert property (@(posedge clk) disable iff (rst)
    (out_valid && out_last) |=> !out_valid)
    else $error("digit transfer after last digit");

  a_char_range: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> ((digit_char >= ASCII_ZERO && digit_char <= ASCII_NINE) ||
                   (digit_char >= ASCII_A && digit_char <= ASCII_F)))
    else $error("digit character out of range");

  a_load_clears: assert property (@(posedge clk) disable iff (rst)
    cmd.load |=> (count == '0 && step == '0 && rem == '0))
    else $error("load did not clear divider state");

  a_store_bound: assert property (@(posedge clk) disable iff (rst)
    digit_we |-> (count < CW'(MAX_DIGITS)))
    else $error("digit store write beyond depth");

endmodule

/* rtl/radix_to_ascii_digits.sv */
// top level: integer to base 2..16 ascii digit string, most significant digit first
// operation: the short divider makes one pass over the value per digit and stores each
// remainder digit, then the digits are emitted one per cycle, most significant first
// a new value is taken only while busy is low, after the flush state that follows the
// last digit; the short divider produces 8 quotient bits per cycle
// reset: synchronous, radix returns to 10, block idle; receiver cannot stall
module radix_to_ascii_digits import rtad_pkg::*; #(
  parameter int VALUE_BITS = 31,
  parameter int MAX_DIGITS = 31
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  start,
  output logic                  busy,
  input  logic [VALUE_BITS-1:0] value,
  input  logic                  radix_we,
  input  logic [RADIX_W-1:0]    radix,
  output logic                  digit_valid,
  output logic [CHAR_W-1:0]     digit_char,
  output logic                  last_digit
);

  rtad_cmd_t    cmd;
  rtad_status_t status;

  rtad_ctrl u_ctrl (
    .clk   (clk),
    .rst   (rst),
    .start (start),
    .status(status),
    .cmd   (cmd),
    .busy  (busy)
  );

  rtad_dpath #(
    .VALUE_BITS(VALUE_BITS),
    .MAX_DIGITS(MAX_DIGITS)
  ) u_dpath (
    .clk        (clk),
    .rst        (rst),
    .cmd        (cmd),
    .status     (status),
    .value      (value),
    .radix_we   (radix_we),
    .radix      (radix),
    .digit_valid(digit_valid),
    .digit_char (digit_char),
    .last_digit (last_digit)
  );

endmodule

/* verif/digit_string_check.sv */
// checker for the radix to ascii digit converter: predicts each digit string and compares
module digit_string_check import rtad_pkg::*; #(
  parameter int VALUE_BITS = 31,
  parameter int MAX_DIGITS = 31
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  start,
  input  logic                  busy,
  input  logic [VALUE_BITS-1:0] value,
  input  logic                  radix_we,
  input  logic [RADIX_W-1:0]    radix,
  input  logic                  digit_valid,
  input  logic [CHAR_W-1:0]     digit_char,
  input  logic                  last_digit,
  output int                    mismatch_count,
  output int                    due_count
);
  timeunit 1ns;
  timeprecision 1ps;

  localparam string GLYPHS = "0123456789ABCDEF";

  typedef struct packed {
    logic [CHAR_W-1:0] ch;
    logic              fin;
  } digit_t;

  digit_t digits_due[$];
  logic [RADIX_W-1:0] base_reg = RADIX_RESET;

  function automatic logic [RADIX_W-1:0] clamp_base(input logic [RADIX_W-1:0] r);
    if (r < RADIX_MIN) begin
      return RADIX_MIN;
    end
    if (r > RADIX_MAX) begin
      return RADIX_MAX;
    end
    return r;
  endfunction

  // digits least significant first, then queued most significant first
  function automatic void expand_digits(input logic [VALUE_BITS-1:0] v,
                                        input logic [RADIX_W-1:0] r);
    logic [DIGIT_W-1:0]    store [MAX_DIGITS];
    logic [VALUE_BITS-1:0] q;
    logic [VALUE_BITS-1:0] b;
    int                    n;
    digit_t                e;
    b = VALUE_BITS'(clamp_base(r));
    q = v;
    n = 0;
    do begin
      store[n] = DIGIT_W'(q % b);
      q = q / b;
      n++;
    end while (q != 0 && n < MAX_DIGITS);
    for (int k = n; k > 0; k--) begin
      e.ch = CHAR_W'(GLYPHS[store[k-1]]);
      e.fin = (k == 1);
      digits_due.push_back(e);
    end
  endfunction

  function automatic void flag(input string msg);
    mismatch_count++;
    if (mismatch_count <= 10) begin
      $display("%t digit_string_check: %s", $realtime, msg);
    end
  endfunction

  always @(posedge clk) begin
    digit_t e;
    if (rst) begin
      base_reg = RADIX_RESET;
      digits_due.delete();
      mismatch_count = 0;
    end else begin
      if (digit_valid) begin
        if (digits_due.size() == 0) begin
          flag($sformatf("unexpected digit char %0d last %0b", digit_char, last_digit));
        end else begin
          e = digits_due.pop_front();
          if (digit_char !== e.ch || last_digit !== e.fin) begin
            flag($sformatf("digit char exp %0d got %0d, last exp %0b got %0b",
                           e.ch, digit_char, e.fin, last_digit));
          end
        end
      end
      // a radix write on the same edge as a value transfer applies to that value
      if (radix_we) begin
        base_reg = radix;
      end
      if (start && !busy) begin
        expand_digits(value, base_reg);
      end
    end
    due_count <= digits_due.size();
  end

endmodule

/* verif/tb_top.sv */
// testbench top for the radix to ascii digit converter: stimulus, radix phases and verdict
module tb_top;
  import rtad_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int VB = 31;
  localparam int MD = 31;

  logic              clk;
  logic              rst;
  logic              start;
  logic              busy;
  logic [VB-1:0]     value;
  logic              radix_we;
  logic [RADIX_W-1:0] radix;
  logic              digit_valid;
  logic [CHAR_W-1:0] digit_char;
  logic              last_digit;
  int                mismatch_count;
  int                due_count;
  bit                quiet;

  radix_to_ascii_digits #(.VALUE_BITS(VB), .MAX_DIGITS(MD)) i_dut (
    .clk        (clk),
    .rst        (rst),
    .start      (start),
    .busy       (busy),
    .value      (value),
    .radix_we   (radix_we),
    .radix      (radix),
    .digit_valid(digit_valid),
    .digit_char (digit_char),
    .last_digit (last_digit)
  );

  digit_string_check #(.VALUE_BITS(VB), .MAX_DIGITS(MD)) i_check (
    .clk           (clk),
    .rst           (rst),
    .start         (start),
    .busy          (busy),
    .value         (value),
    .radix_we      (radix_we),
    .radix         (radix),
    .digit_valid   (digit_valid),
    .digit_char    (digit_char),
    .last_digit    (last_digit),
    .mismatch_count(mismatch_count),
    .due_count     (due_count)
  );

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  initial begin
    #5_000_000;
    $display("tb_top: FAIL");
    $finish;
  end

  task automatic send_value(input logic [VB-1:0] v);
    bit taken;
    if (!quiet && $urandom_range(99) < 10) begin
      start <= 1'b0;
      repeat ($urandom_range(1, 40)) @(negedge clk);
    end
    start <= 1'b1;
    value <= v;
    taken = 1'b0;
    while (!taken) begin
      @(posedge clk);
      taken = !busy;
      @(negedge clk);
    end
  endtask

  task automatic drain();
    start <= 1'b0;
    while (due_count != 0 || busy) @(negedge clk);
  endtask

  task automatic set_radix(input logic [RADIX_W-1:0] r);
    drain();
    repeat (4) @(negedge clk);
    radix_we <= 1'b1;
    radix <= r;
    @(negedge clk);
    radix_we <= 1'b0;
  endtask

  function automatic logic [VB-1:0] random_value(input logic [RADIX_W-1:0] r);
    longint unsigned b;
    longint unsigned p;
    int k;
    b = (r < RADIX_MIN) ? RADIX_MIN : ((r > RADIX_MAX) ? RADIX_MAX : r);
    case ($urandom_range(5))
      0: return VB'($urandom);
      1: return VB'($urandom_range(0, 40));
      2: return VB'($urandom_range(0, 5000));
      3: return {VB{1'b1}} - VB'($urandom_range(0, 3));
      4: begin
        p = 1;
        k = $urandom_range(0, 30);
        while (k > 0 && p * b < (64'd1 << VB)) begin
          p = p * b;
          k--;
        end
        return VB'(p - $urandom_range(0, 1));
      end
      default: return VB'($urandom & $urandom);
    endcase
  endfunction

  initial begin
    logic [RADIX_W-1:0] r;
    rst = 1'b1;
    start = 1'b0;
    value = '0;
    radix_we = 1'b0;
    radix = RADIX_RESET;
    quiet = 1'b0;
    repeat (8) @(negedge clk);
    rst <= 1'b0;

    // directed: decimal after reset
    send_value(31'd0);
    send_value(31'd1);
    send_value(31'd9);
    send_value(31'd10);
    send_value(31'h7FFF_FFFF);
    send_value(31'd1_000_000_000);
    set_radix(5'd2);
    send_value(31'd0);
    send_value(31'd1);
    send_value(31'h7FFF_FFFF);
    send_value(31'h5555_5555);
    set_radix(5'd16);
    send_value(31'h7FFF_FFFF);
    send_value(31'h00AB_CDEF);
    send_value(31'd15);
    send_value(31'd16);
    send_value(31'h7EDC_BA98);
    // out of range bases clamp to two and sixteen
    set_radix(5'd0);
    send_value(31'd5);
    set_radix(5'd1);
    send_value(31'd6);
    set_radix(5'd17);
    send_value(31'd255);
    set_radix(5'd31);
    send_value(31'h7FED_CBA9);
    set_radix(5'd3);
    send_value(31'h7FFF_FFFF);
    set_radix(5'd7);
    send_value(31'd48);

    for (int ph = 0; ph < 10; ph++) begin
      if (ph == 0) begin
        r = RADIX_MIN;
      end else if (ph == 1) begin
        r = RADIX_MAX;
      end else if ($urandom_range(9) == 0) begin
        r = RADIX_W'($urandom_range(0, 31));
      end else begin
        r = RADIX_W'($urandom_range(2, 16));
      end
      set_radix(r);
      quiet = (ph == 3);
      for (int i = 0; i < 29; i++) begin
        send_value(random_value(r));
      end
    end
    quiet = 1'b0;

    drain();
    repeat (60) @(negedge clk);
    if (mismatch_count == 0 && due_count == 0) begin
      $display("tb_top: PASS");
    end else begin
      $display("tb_top: FAIL");
    end
    $finish;
  end

endmodule

/* files.f */
rtl/rtad_pkg.sv
rtl/rtad_ram.sv
rtl/rtad_ctrl.sv
rtl/rtad_dpath.sv
rtl/radix_to_ascii_digits.sv
verif/digit_string_check.sv
verif/tb_top.sv
